// ----- hw/rtl/binary_to_decimal_ascii_assert.svh -----
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BDASC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bdasc assertion failed");

// Next-cycle implication, checked out of reset
`define BDASC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bdasc assertion failed");

`endif

// ----- hw/rtl/bdasc_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
`default_nettype none

package bdasc_pkg;

	// One output character
	typedef logic [7:0] char_t;

	// ASCII codes that are emitted
	localparam char_t ASCII_ZERO  = 8'h30;
	localparam char_t ASCII_MINUS = 8'h2D;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_WIDTH_SELECT = 2'd0;
	localparam cfg_idx_t CFG_SIGNED_MODE  = 2'd1;

	// Operand width codes
	typedef logic [1:0] wsel_t;
	localparam wsel_t WSEL_8  = 2'd0;
	localparam wsel_t WSEL_16 = 2'd1;
	localparam wsel_t WSEL_32 = 2'd2;
	localparam wsel_t WSEL_64 = 2'd3;

	// Double dabble digit correction
	typedef logic [3:0] bcd_digit_t;
	localparam bcd_digit_t BCD_ADJ_LIMIT = 4'd5;
	localparam bcd_digit_t BCD_ADJ       = 4'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/bdasc_dabble_step.sv -----
// One double dabble step: add-3 correction of every BCD digit, then shift in one bit.
`default_nettype none

module bdasc_dabble_step #(
	parameter int NUM_DIGITS = 20
) (
	input  wire logic [4*NUM_DIGITS-1:0] bcd_in,
	input  wire logic                    bin_msb,
	output logic      [4*NUM_DIGITS-1:0] bcd_out
);
	import bdasc_pkg::*;

	logic [4*NUM_DIGITS-1:0] adjusted;

	// Digits of five or more get three added before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_in[4*i +: 4] >= BCD_ADJ_LIMIT) begin
				adjusted[4*i +: 4] = bcd_in[4*i +: 4] + BCD_ADJ;
			end else begin
				adjusted[4*i +: 4] = bcd_in[4*i +: 4];
			end
		end
	end

	assign bcd_out = {adjusted[4*NUM_DIGITS-2:0], bin_msb};

endmodule

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter: config, sequencer, shared dabble step, char output.
// Per number: accept, then W double dabble steps (W = operand width, 8..MAX_WIDTH),
// then skip leading zeros and send the digits, led by a minus sign if negative.
// Output stalls hold the sequencer in the sign and emit states.
// One number is in work at a time; in_stall is high until its last character is loaded.
// Reset clears the sequencer and output valid; width_select resets to 32 bits, signed_mode to 1.
`default_nettype none

module binary_to_decimal_ascii #(
	parameter int MAX_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire bdasc_pkg::cfg_idx_t   cfg_index,
	input  wire bdasc_pkg::cfg_data_t  cfg_wdata,
	// input requests
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [63:0]           value,
	// output requests
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output bdasc_pkg::char_t           char_code,
	output logic                       last_char
);
	import bdasc_pkg::*;

	localparam int NUM_DIGITS = (MAX_WIDTH * 30103) / 100000 + 1;
	localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
	localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
	localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [MAX_WIDTH-1:0]    bin_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic [4*NUM_DIGITS-1:0] bcd_step;
	logic                    neg_q;
	logic [DIG_W-1:0]        dig_left_q;
	wsel_t                   width_select_q;
	logic                    signed_mode_q;
	logic                    out_valid_q;
	char_t                   char_q;
	logic                    last_q;

	logic [6:0]              w_full;
	logic [CNT_W-1:0]        op_w;
	logic [CNT_W-1:0]        align_sh;
	logic [MAX_WIDTH-1:0]    x_al;
	logic                    in_neg;
	logic                    in_fire;
	logic                    slot_free;
	bcd_digit_t              top_digit;
	logic                    load_char;
	char_t                   next_char;
	logic                    next_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_select_q <= WSEL_32;
			signed_mode_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH_SELECT: width_select_q <= cfg_wdata[1:0];
				CFG_SIGNED_MODE:  signed_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Operand width, capped at MAX_WIDTH
	always_comb begin
		unique case (width_select_q)
			WSEL_8:  w_full = 7'd8;
			WSEL_16: w_full = 7'd16;
			WSEL_32: w_full = 7'd32;
			WSEL_64: w_full = 7'd64;
			default: w_full = 7'd32;
		endcase
	end

	assign op_w     = (w_full > MAX_W7) ? CNT_W'(MAX_WIDTH) : CNT_W'(w_full);
	assign align_sh = CNT_W'(MAX_WIDTH) - op_w;

	// Left-align the operand so its sign bit is the top bit; negation commutes with it
	assign x_al   = value[MAX_WIDTH-1:0] << align_sh;
	assign in_neg = signed_mode_q & x_al[MAX_WIDTH-1];

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid & ~in_stall;

	// Shared add-3 and shift unit
	bdasc_dabble_step #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_step (
		.bcd_in (bcd_q),
		.bin_msb(bin_q[MAX_WIDTH-1]),
		.bcd_out(bcd_step)
	);

	assign top_digit = bcd_q[4*NUM_DIGITS-1 -: 4];
	assign slot_free = ~out_valid_q | ~out_stall;

	// Character to load into the output register
	always_comb begin
		load_char = 1'b0;
		next_char = ASCII_ZERO + char_t'(top_digit);
		next_last = (dig_left_q == DIG_W'(1));
		if (state_q == ST_SIGN) begin
			load_char = slot_free;
			next_char = ASCII_MINUS;
			next_last = 1'b0;
		end else if (state_q == ST_EMIT) begin
			load_char = slot_free;
		end
	end

	// Sequencer: load, convert, skip leading zeros, minus sign if negative, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dig_left_q <= '0;
			neg_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q    <= ST_CONV;
						cnt_q      <= op_w;
						neg_q      <= in_neg;
						dig_left_q <= DIG_W'(NUM_DIGITS);
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_digit == '0 && dig_left_q > DIG_W'(1)) begin
						dig_left_q <= dig_left_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						dig_left_q <= dig_left_q - 1'b1;
						if (dig_left_q == DIG_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: binary and BCD shift registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			bin_q <= in_neg ? (~x_al + 1'b1) : x_al;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= bin_q << 1;
			bcd_q <= bcd_step;
		end else if ((state_q == ST_SKIP && top_digit == '0 && dig_left_q > DIG_W'(1)) ||
				(state_q == ST_EMIT && slot_free)) begin
			bcd_q <= bcd_q << 4;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_char) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_char) begin
			char_q <= next_char;
			last_q <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

	`include "binary_to_decimal_ascii_assert.svh"

	// An accepted number always starts a conversion
	`BDASC_ASSERT_NEXT(a_load_to_conv, clk, arst_n, in_fire, state_q == ST_CONV)
	// The iteration count never runs out while converting
	`BDASC_ASSERT_NOW(a_conv_cnt, clk, arst_n, state_q == ST_CONV, cnt_q != '0)
	// A minus sign never closes a number
	`BDASC_ASSERT_NOW(a_minus_not_last, clk, arst_n, out_valid_q && char_q == ASCII_MINUS, !last_q)

endmodule

`default_nettype wire

// ----- tb/binary_to_decimal_ascii_test.sv -----
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_test;
	import bdasc_pkg::*;

	// Register indexes with no register behind them
	localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
	localparam cfg_idx_t CFG_SPARE_HI = 2'd3;

	// signed_mode write data; the upper data bit is not part of the register
	localparam cfg_data_t MODE_UNSIGNED  = 2'd0;
	localparam cfg_data_t MODE_SIGNED    = 2'd1;
	localparam cfg_data_t MODE_SPARE_BIT = 2'd2;

	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 29;
	localparam int RANDOM_PHASES = 8;
	localparam int SETTLE_CYCLES = 100;

	typedef struct packed {
		char_t code;
		logic  last;
	} decimal_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_idx_t    cfg_index = CFG_WIDTH_SELECT;
	cfg_data_t   cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	char_t       char_code;
	logic        last_char;

	// Shadow of the block's registers, as of the last write
	wsel_t cur_wsel = WSEL_32;
	logic  cur_signed = 1'b1;

	logic [63:0]   pending_values[$];
	decimal_char_t expected_text[$];
	int            mismatches = 0;
	int            quiet_cycles = 0;
	int            send_gap = 0;
	int            stall_left = 0;
	bit            in_gaps_on = 1'b1;
	bit            out_gaps_on = 1'b1;

	binary_to_decimal_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	function automatic int unsigned operand_bits();
		return 8 << cur_wsel;
	endfunction

	function automatic logic [63:0] operand_mask();
		return (operand_bits() == 64) ? '1 : ((64'd1 << operand_bits()) - 64'd1);
	endfunction

	// Decimal text of one number under the current settings, queued as expected
	function automatic void predict_text(logic [63:0] raw);
		logic [63:0] mask;
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  digits[20];
		int          nd;
		int          k;
		mask = operand_mask();
		mag = raw & mask;
		neg = cur_signed && mag[operand_bits() - 1];
		if (neg) begin
			mag = (~mag + 64'd1) & mask;
			expected_text.push_back('{ASCII_MINUS, 1'b0});
		end
		nd = 0;
		do begin
			digits[nd] = 4'(mag % 64'd10);
			nd++;
			mag = mag / 64'd10;
		end while (mag != 0);
		for (k = nd - 1; k >= 0; k--) begin
			expected_text.push_back('{char_t'(ASCII_ZERO + digits[k]), k == 0});
		end
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Random operand, biased toward digit-count and sign boundaries
	function automatic logic [63:0] make_value();
		logic [63:0] v;
		logic [63:0] tens;
		int          k;
		case ($urandom_range(0, 5))
			0: begin
				v = {$urandom, $urandom};
			end
			1: begin
				v = $urandom_range(0, 20);
			end
			2: begin
				tens = 64'd1;
				k = $urandom_range(0, 19);
				repeat (k) tens = tens * 64'd10;
				v = tens + $urandom_range(0, 2) - 64'd1;
			end
			3: begin
				v = (64'd1 << (operand_bits() - 1)) + $urandom_range(0, 2) - 64'd1;
			end
			4: begin
				v = operand_mask() - $urandom_range(0, 2);
			end
			default: begin
				v = ~operand_mask() & {$urandom, $urandom} | $urandom_range(0, 999);
			end
		endcase
		// random garbage above the operand width now and then
		if ($urandom_range(0, 2) == 0) begin
			v = (v & operand_mask()) | ({$urandom, $urandom} & ~operand_mask());
		end
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Register write, tracked in the shadow copy
	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_WIDTH_SELECT: cur_wsel = wsel_t'(data);
			CFG_SIGNED_MODE: cur_signed = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(wsel_t wsel, cfg_data_t mode);
		write_reg(CFG_WIDTH_SELECT, cfg_data_t'(wsel));
		write_reg(CFG_SIGNED_MODE, mode);
	endtask

	// Hold until every queued request is taken and every character is back
	task automatic drain();
		do @(posedge clk);
		while (pending_values.size() != 0 || in_valid || expected_text.size() != 0);
	endtask

	// Request driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_text(value);
		end
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_values.size() != 0) begin
				value <= pending_values.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap(in_gaps_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Character monitor and output stall
	always @(posedge clk) begin
		decimal_char_t want;
		if (out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				report_mismatch("unexpected character", char_code, 0);
			end else begin
				want = expected_text.pop_front();
				if (char_code !== want.code) begin
					report_mismatch("char_code", char_code, want.code);
				end
				if (last_char !== want.last) begin
					report_mismatch("last_char", last_char, want.last);
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap(out_gaps_on);
			out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles without any accepted request or delivered character
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 32-bit signed; zero, sign extremes, ignored upper bits
		pending_values.push_back(64'd0);
		pending_values.push_back(64'd1);
		pending_values.push_back(64'h0000_0000_FFFF_FFFF);
		pending_values.push_back(64'h0000_0000_8000_0000);
		pending_values.push_back(64'h0000_0000_7FFF_FFFF);
		pending_values.push_back(64'hDEAD_BEEF_0000_0005);
		pending_values.push_back(64'h1234_5678_FFFF_FF85);
		drain();

		// Writes to unused indexes change nothing
		write_reg(CFG_SPARE_LO, cfg_data_t'($urandom));
		write_reg(CFG_SPARE_HI, cfg_data_t'($urandom));
		pending_values.push_back(64'h0000_0000_8000_0000);
		drain();

		configure(WSEL_64, MODE_UNSIGNED);
		pending_values.push_back('1);
		pending_values.push_back(64'd0);
		pending_values.push_back(64'd10);
		pending_values.push_back(64'd9);
		pending_values.push_back(64'd10000000000000000000);
		drain();

		configure(WSEL_64, MODE_SIGNED);
		pending_values.push_back(64'h8000_0000_0000_0000);
		pending_values.push_back('1);
		pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
		drain();

		// spare data bit on signed_mode is dropped
		configure(WSEL_8, MODE_SPARE_BIT | MODE_SIGNED);
		pending_values.push_back(64'h80);
		pending_values.push_back(64'h7F);
		pending_values.push_back(64'hFF);
		pending_values.push_back(64'hFFFF_FFFF_FFFF_FF00);
		drain();

		write_reg(CFG_SIGNED_MODE, MODE_SPARE_BIT);
		pending_values.push_back(64'hFF);
		pending_values.push_back(64'h80);
		drain();

		configure(WSEL_16, MODE_SIGNED);
		pending_values.push_back(64'h8000);
		pending_values.push_back(64'hFFFF);
		pending_values.push_back(64'h7FFF);
		drain();

		// Random phases, each under its own settings; the first runs without gaps
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			in_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			out_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			configure(wsel_t'($urandom_range(0, 3)), cfg_data_t'($urandom_range(0, 3)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off mid-phase until all text is back
				if (n == PHASE_ITEMS / 2 && (phase == 1 || $urandom_range(0, 2) == 0)) begin
					drain();
				end
				pending_values.push_back(make_value());
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_text.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
